// ===== rtl/core/stc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// System timer package
// Shared widths, access codes and the configuration bundle of the timer.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 64;
  localparam int FIELD_W = 5;
  localparam int MODE_W  = 2;
  localparam int SEL_W   = 2;
  localparam int INDEX_W = 2;

  // Kind of access carried by one input item. The fourth code does nothing.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  // Register addressed by a bus read or write.
  typedef enum logic [SEL_W-1:0] {
    REG_COUNT_LO   = 2'd0,
    REG_CAPTURE_HI = 2'd1,
    REG_COMPARE    = 2'd2,
    REG_STATUS     = 2'd3
  } reg_sel_t;

  // Configuration register indexes.
  typedef enum logic [INDEX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_START  = 2'd1,
    CFG_SIZE   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic               enable;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] size;
  } cfg_t;

  localparam logic [FIELD_W-1:0] SIZE_RESET = 5'd31;

endpackage : stc_pkg
`default_nettype wire

// ===== rtl/core/stc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer configuration registers
// Holds the compare enable, field start and field size written by the host.
// ----------------------------------------------------------------------------
module stc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [stc_pkg::INDEX_W-1:0] cfg_index,
  input  wire logic [stc_pkg::WORD_W-1:0]  cfg_data,
  output stc_pkg::cfg_t                    cfg
);
  import stc_pkg::*;

  cfg_index_t idx;

  assign cfg_ready = 1'b1;
  assign idx       = cfg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.start  <= '0;
      cfg.size   <= SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (idx)
        CFG_ENABLE: cfg.enable <= cfg_data[0];
        CFG_START:  cfg.start  <= cfg_data[FIELD_W-1:0];
        CFG_SIZE:   cfg.size   <= cfg_data[FIELD_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule : stc_cfg_regs
`default_nettype wire

// ===== rtl/core/stc_timer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer core
// Counter, capture, compare and flag state with the result of one access.
// ----------------------------------------------------------------------------
module stc_timer_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       fire,
  input  wire logic [stc_pkg::MODE_W-1:0] mode,
  input  wire logic [stc_pkg::SEL_W-1:0]  reg_select,
  input  wire logic [stc_pkg::WORD_W-1:0] write_data,
  input  wire stc_pkg::cfg_t              cfg,
  output logic [stc_pkg::WORD_W-1:0]      rdata_next,
  output logic                            irq_next
);
  import stc_pkg::*;

  logic [COUNT_W-1:0] counter, counter_next, counter_inc;
  logic [WORD_W-1:0]  shifted;
  logic [WORD_W-1:0]  capture_high, capture_high_next;
  logic [WORD_W-1:0]  compare_value, compare_value_next;
  logic               irq_flag, irq_flag_next;
  logic [WORD_W-1:0]  mask;
  logic               match;
  mode_t              m;
  reg_sel_t           sel;

  assign m   = mode_t'(mode);
  assign sel = reg_sel_t'(reg_select);

  // Field compare on the incremented count. The field is at most one word
  // wide, so only the low word of the shifted count takes part.
  assign counter_inc = counter + COUNT_W'(1);
  assign shifted     = WORD_W'(counter_inc >> cfg.start);
  assign mask        = {WORD_W{1'b1}} >> (FIELD_W'(WORD_W - 1) - cfg.size);
  assign match       = (shifted & mask) == (compare_value & mask);

  always_comb begin
    counter_next       = counter;
    capture_high_next  = capture_high;
    compare_value_next = compare_value;
    irq_flag_next      = irq_flag;
    rdata_next         = '0;
    case (m)
      MODE_TICK: begin
        counter_next = counter_inc;
        if (match) begin
          irq_flag_next = 1'b1;
        end
      end
      MODE_READ: begin
        unique case (sel)
          REG_COUNT_LO: begin
            rdata_next        = counter[WORD_W-1:0];
            capture_high_next = counter[COUNT_W-1:WORD_W];
          end
          REG_CAPTURE_HI: rdata_next = capture_high;
          REG_COMPARE:    rdata_next = compare_value;
          REG_STATUS:     rdata_next = {{(WORD_W-1){1'b0}}, irq_flag};
          default: begin
          end
        endcase
      end
      MODE_WRITE: begin
        if (sel == REG_COMPARE) begin
          compare_value_next = write_data;
        end else if (sel == REG_STATUS && write_data[0]) begin
          irq_flag_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
    irq_next = irq_flag_next & cfg.enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter       <= '0;
      capture_high  <= '0;
      compare_value <= '0;
      irq_flag      <= 1'b0;
    end else if (fire) begin
      counter       <= counter_next;
      capture_high  <= capture_high_next;
      compare_value <= compare_value_next;
      irq_flag      <= irq_flag_next;
    end
  end

endmodule : stc_timer_core
`default_nettype wire

// ===== rtl/core/system_timer_compare_capture.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// System timer with compare and capture
// A 64-bit tick counter with a high-word capture, a field compare and an
// interrupt flag, driven by a stream of tick and register access items.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake           Payload
//   -------  ------------------  --------------------------------
//   in       in_valid/in_ready   mode, reg_select, write_data
//   out      out_valid/out_ready read_data, irq
//   cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each item is taken into an input register; when it advances, the timer
// core applies it to the state and its result is loaded into the output
// register, which raises out_valid.
// One item is accepted in every cycle when the output side keeps up; the
// single-cycle path is the 64-bit increment followed by the field compare.
// Reset is synchronous and clears the valid bits of both pipeline registers and all timer state.
// A stalled output holds the result; an item that reaches the input register
// meanwhile waits there, and in_ready stays low until the output register frees.
// Configuration transfers are always accepted and take effect once registered.
//
module system_timer_compare_capture (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [stc_pkg::MODE_W-1:0]  mode,
  input  wire logic [stc_pkg::SEL_W-1:0]   reg_select,
  input  wire logic [stc_pkg::WORD_W-1:0]  write_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [stc_pkg::WORD_W-1:0]       read_data,
  output logic                             irq,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [stc_pkg::INDEX_W-1:0] cfg_index,
  input  wire logic [stc_pkg::WORD_W-1:0]  cfg_data
);
  import stc_pkg::*;

  cfg_t              cfg;
  logic              stg_valid;
  logic [MODE_W-1:0] stg_mode;
  logic [SEL_W-1:0]  stg_sel;
  logic [WORD_W-1:0] stg_wdata;
  logic              adv;
  logic [WORD_W-1:0] rdata_next;
  logic              irq_next;

  // The staged item advances whenever the output register is empty or is
  // being emptied by a transfer in this cycle.
  assign adv      = stg_valid && (!out_valid || out_ready);
  assign in_ready = !stg_valid || adv;

  stc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stc_timer_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (adv),
    .mode       (stg_mode),
    .reg_select (stg_sel),
    .write_data (stg_wdata),
    .cfg        (cfg),
    .rdata_next (rdata_next),
    .irq_next   (irq_next)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_mode  <= mode;
      stg_sel   <= reg_select;
      stg_wdata <= write_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_data <= rdata_next;
      irq       <= irq_next;
    end
  end

  // An item in the input register is never dropped while it waits.
  a_stage_kept : assert property (@(posedge clk) disable iff (rst)
    stg_valid && !adv |=> stg_valid)
    else $error("staged item lost while stalled");

  // Every item that leaves the input register lands in the result register.
  a_adv_result : assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("advanced item produced no result");

  // Only read accesses return data.
  a_rdata_zero : assert property (@(posedge clk) disable iff (rst)
    adv && stg_mode != MODE_READ |=> read_data == '0)
    else $error("non-read access returned data");

  // Reset empties both pipeline registers.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid && !stg_valid)
    else $error("pipeline not empty after reset");

endmodule : system_timer_compare_capture
`default_nettype wire
